FILE: design/multiclass_perceptron_top_defines.svh
`ifndef MULTICLASS_PERCEPTRON_TOP_DEFINES_SVH
`define MULTICLASS_PERCEPTRON_TOP_DEFINES_SVH

// clocked assertion, off while reset is high
`define MP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion, also checked during reset
`define MP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/mp_pkg.sv
package mp_pkg;

  localparam int MAX_FEATURES = 64;
  localparam int MAX_CLASSES  = 16;
  localparam int FEAT_W       = 16;
  localparam int WEIGHT_W     = 32;
  localparam int LOGIT_W      = 48;
  localparam int CLS_W        = 4;
  localparam int IDX_W        = 6;
  localparam int ADDR_W       = 10;
  localparam int WDEPTH       = MAX_FEATURES * MAX_CLASSES;
  localparam int ACC_W        = 56;
  localparam int LEN_W        = 7;
  localparam int ACT_W        = 5;
  localparam int STEP_W       = 16;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;
  localparam int S_DATA_W     = 24;
  localparam int M_DATA_W     = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_VECTOR_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTION_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE     = 2'd2;

  localparam logic [1:0] PH_READ  = 2'd0;
  localparam logic [1:0] PH_MUL   = 2'd1;
  localparam logic [1:0] PH_WRITE = 2'd2;

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_LOAD  = 6'b000010,
    ST_COMP  = 6'b000100,
    ST_TRAIN = 6'b001000,
    ST_EMIT  = 6'b010000,
    ST_ERR   = 6'b100000
  } state_t;

endpackage

FILE: design/multiclass_perceptron_top.sv
// Multiclass perceptron classifier. Features stream in one per transfer on the
// slave side; the transfer that completes a vector of vector_length features
// also carries the opcode (tuser) and the target class. The block then computes
// every logit with one shared 16x32 multiplier fed by a weight memory with
// one read and one write port, one MAC per cycle. In train mode a
// mispredicted vector adds a read-modify-write pass over the target and
// predicted rows, in which each weight is read, updated and written back.
// Then action_count results leave on the master side, one per transfer, the
// last with tlast. A bad training request gives a single result with tuser
// set. Input is taken only while no vector is at work. After reset and after
// each write of vector_length or action_count the weight memory is cleared by
// a pass over all 1024 words during which no input is taken.
`include "multiclass_perceptron_top_defines.svh"

module multiclass_perceptron_top
  import mp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [S_DATA_W-1:0]   s_tdata,   // feature[15:0], target_class[19:16], zero pad
  input  logic                  s_tuser,   // opcode
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_DATA_W-1:0]   m_tdata,   // class_index[3:0], logit_value[51:4],
                                           // best_class[55:52], updated[56], zero pad
  output logic                  m_tuser,   // status
  output logic                  m_tlast,   // last_result
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  state_t state;

  logic [LEN_W-1:0]  len_reg, len_eff;
  logic [ACT_W-1:0]  acts_reg, acts_eff;
  logic [STEP_W-1:0] step_reg;

  logic signed [FEAT_W-1:0]   vbuf [MAX_FEATURES];
  logic signed [WEIGHT_W-1:0] wmem [WDEPTH];
  logic signed [WEIGHT_W-1:0] bias [MAX_CLASSES];
  logic signed [LOGIT_W-1:0]  logits [MAX_CLASSES];

  logic signed [FEAT_W-1:0]   vb_rd;
  logic signed [WEIGHT_W-1:0] w_rd;
  logic [IDX_W-1:0]           vb_raddr;
  logic [ADDR_W-1:0]          w_raddr, w_waddr, clr_addr;
  logic                       w_we;
  logic signed [WEIGHT_W-1:0] w_wdata;

  logic [IDX_W-1:0] cnt;
  logic             op;
  logic [CLS_W-1:0] tgt;

  logic [CLS_W-1:0] ca;
  logic [IDX_W-1:0] ci;
  logic             issuing;
  logic             p1_v, p1_first, p1_last;
  logic [CLS_W-1:0] p1_a;
  logic             p2_v, p2_first, p2_last;
  logic [CLS_W-1:0] p2_a;
  logic signed [LOGIT_W-1:0] prod;
  logic signed [ACC_W-1:0]   acc, acc_next, fin;
  logic             fin_v;
  logic [CLS_W-1:0] fin_a;
  logic signed [LOGIT_W-1:0] fin_logit, best_val;
  logic [CLS_W-1:0] best, best_new;
  logic             upd;

  logic             tsub;
  logic [IDX_W-1:0] ti;
  logic [1:0]       tph;
  logic [CLS_W-1:0] trow;
  logic signed [32:0] tprod;
  logic signed [20:0] delta;
  logic signed [WEIGHT_W-1:0] wcur;
  logic signed [32:0] wsum, bsum;
  logic signed [WEIGHT_W-1:0] wsat, bsat, bias_rd;
  logic [CLS_W-1:0] bias_raddr;

  logic [CLS_W-1:0] ea;

  logic [CLS_W-1:0]  row_sel;
  logic [IDX_W-1:0]  col_sel;
  logic [ADDR_W-1:0] row_addr;

  // effective sizes
  always_comb begin
    if (len_reg == '0) begin
      len_eff = LEN_W'(1);
    end else if (len_reg > LEN_W'(MAX_FEATURES)) begin
      len_eff = LEN_W'(MAX_FEATURES);
    end else begin
      len_eff = len_reg;
    end
    if (acts_reg == '0) begin
      acts_eff = ACT_W'(1);
    end else if (acts_reg > ACT_W'(MAX_CLASSES)) begin
      acts_eff = ACT_W'(MAX_CLASSES);
    end else begin
      acts_eff = acts_reg;
    end
  end

  assign trow     = tsub ? best : tgt;
  assign row_sel  = (state == ST_TRAIN) ? trow : ca;
  assign col_sel  = (state == ST_TRAIN) ? ti : ci;
  assign row_addr = ADDR_W'(row_sel) * ADDR_W'(len_eff) + ADDR_W'(col_sel);
  assign w_raddr  = row_addr;
  assign vb_raddr = col_sel;

  // training arithmetic
  assign tprod = $signed({1'b0, step_reg}) * vb_rd;
  always_comb begin
    if (tsub) begin
      wsum = {wcur[WEIGHT_W-1], wcur} - {{12{delta[20]}}, delta};
    end else begin
      wsum = {wcur[WEIGHT_W-1], wcur} + {{12{delta[20]}}, delta};
    end
    if (wsum[32] != wsum[31]) begin
      wsat = wsum[32] ? {1'b1, {(WEIGHT_W-1){1'b0}}} : {1'b0, {(WEIGHT_W-1){1'b1}}};
    end else begin
      wsat = wsum[WEIGHT_W-1:0];
    end
  end

  assign bias_raddr = (state == ST_TRAIN) ? trow : p2_a;
  assign bias_rd    = bias[bias_raddr];
  always_comb begin
    if (tsub) begin
      bsum = {bias_rd[WEIGHT_W-1], bias_rd} - {17'b0, step_reg};
    end else begin
      bsum = {bias_rd[WEIGHT_W-1], bias_rd} + {17'b0, step_reg};
    end
    if (bsum[32] != bsum[31]) begin
      bsat = bsum[32] ? {1'b1, {(WEIGHT_W-1){1'b0}}} : {1'b0, {(WEIGHT_W-1){1'b1}}};
    end else begin
      bsat = bsum[WEIGHT_W-1:0];
    end
  end

  // weight write port
  always_comb begin
    w_we    = 1'b0;
    w_waddr = w_raddr;
    w_wdata = wsat;
    if (state == ST_CLEAR) begin
      w_we    = 1'b1;
      w_waddr = clr_addr;
      w_wdata = '0;
    end else if (state == ST_TRAIN && tph == PH_WRITE) begin
      w_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (w_we) begin
      wmem[w_waddr] <= w_wdata;
    end
    w_rd <= wmem[w_raddr];
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      vbuf[cnt] <= $signed(s_tdata[FEAT_W-1:0]);
    end
    vb_rd <= vbuf[vb_raddr];
  end

  // logit accumulation
  assign acc_next = (p2_first ? {{12{bias_rd[WEIGHT_W-1]}}, bias_rd, 12'b0} : acc)
                  + {{(ACC_W-LOGIT_W){prod[LOGIT_W-1]}}, prod};
  assign fin_logit = {{4{fin[ACC_W-1]}}, fin[ACC_W-1:12]};
  assign best_new  = (fin_a == '0 || fin_logit > best_val) ? fin_a : best;

  always_ff @(posedge clk) begin
    prod <= vb_rd * w_rd;
    p1_first <= (ci == '0);
    p1_last  <= (7'(ci) == len_eff - 7'd1);
    p1_a     <= ca;
    p2_first <= p1_first;
    p2_last  <= p1_last;
    p2_a     <= p1_a;
    if (p2_v) begin
      acc <= acc_next;
    end
    fin   <= acc_next;
    fin_a <= p2_a;
    if (fin_v) begin
      logits[fin_a] <= fin_logit;
      best          <= best_new;
      if (best_new == fin_a) begin
        best_val <= fin_logit;
      end
    end
    if (state == ST_TRAIN && tph == PH_MUL) begin
      delta <= tprod[32:12];
      wcur  <= w_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v  <= 1'b0;
      p2_v  <= 1'b0;
      fin_v <= 1'b0;
    end else begin
      p1_v  <= (state == ST_COMP) && issuing;
      p2_v  <= p1_v;
      fin_v <= p2_v && p2_last;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      len_reg  <= LEN_W'(1);
      acts_reg <= ACT_W'(2);
      step_reg <= STEP_W'(4096);
      cnt      <= '0;
      op       <= 1'b0;
      tgt      <= '0;
      ca       <= '0;
      ci       <= '0;
      issuing  <= 1'b0;
      upd      <= 1'b0;
      tsub     <= 1'b0;
      ti       <= '0;
      tph      <= PH_READ;
      ea       <= '0;
      for (int k = 0; k < MAX_CLASSES; k++) begin
        bias[k] <= '0;
      end
    end else begin
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == ADDR_W'(WDEPTH - 1)) begin
            state <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          if (s_tvalid) begin
            if (7'(cnt) + 7'd1 == len_eff) begin
              cnt <= '0;
              op  <= s_tuser;
              tgt <= s_tdata[FEAT_W+CLS_W-1:FEAT_W];
              ea  <= '0;
              if (s_tuser && (5'(s_tdata[FEAT_W+CLS_W-1:FEAT_W]) >= acts_eff
                              || step_reg == '0)) begin
                state <= ST_ERR;
              end else begin
                state   <= ST_COMP;
                ca      <= '0;
                ci      <= '0;
                issuing <= 1'b1;
              end
            end else begin
              cnt <= cnt + IDX_W'(1);
            end
          end
        end
        ST_COMP: begin
          if (issuing) begin
            if (7'(ci) == len_eff - 7'd1) begin
              ci <= '0;
              ca <= ca + CLS_W'(1);
              if (5'(ca) == acts_eff - 5'd1) begin
                issuing <= 1'b0;
              end
            end else begin
              ci <= ci + IDX_W'(1);
            end
          end
          if (fin_v && 5'(fin_a) == acts_eff - 5'd1) begin
            upd  <= op && (best_new != tgt);
            tsub <= 1'b0;
            ti   <= '0;
            tph  <= PH_READ;
            state <= (op && (best_new != tgt)) ? ST_TRAIN : ST_EMIT;
          end
        end
        ST_TRAIN: begin
          case (tph)
            PH_READ: begin
              tph <= PH_MUL;
              if (ti == '0) begin
                bias[trow] <= bsat;
              end
            end
            PH_MUL: tph <= PH_WRITE;
            default: begin
              tph <= PH_READ;
              if (7'(ti) == len_eff - 7'd1) begin
                ti <= '0;
                if (tsub) begin
                  state <= ST_EMIT;
                end else begin
                  tsub <= 1'b1;
                end
              end else begin
                ti <= ti + IDX_W'(1);
              end
            end
          endcase
        end
        ST_EMIT: begin
          if (m_tready) begin
            ea <= ea + CLS_W'(1);
            if (5'(ea) == acts_eff - 5'd1) begin
              state <= ST_LOAD;
            end
          end
        end
        ST_ERR: begin
          if (m_tready) begin
            state <= ST_LOAD;
          end
        end
        default: state <= ST_CLEAR;
      endcase

      if (cfg_we) begin
        unique case (cfg_index) inside
          CFG_VECTOR_LENGTH, CFG_ACTION_COUNT: begin
            if (cfg_index == CFG_VECTOR_LENGTH) begin
              len_reg <= cfg_data[LEN_W-1:0];
            end else begin
              acts_reg <= cfg_data[ACT_W-1:0];
            end
            cnt      <= '0;
            state    <= ST_CLEAR;
            clr_addr <= '0;
            for (int k = 0; k < MAX_CLASSES; k++) begin
              bias[k] <= '0;
            end
          end
          CFG_STEP_SIZE: step_reg <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // result channel
  assign s_tready = (state == ST_LOAD);
  assign m_tvalid = (state == ST_EMIT) || (state == ST_ERR);
  assign m_tuser  = (state == ST_ERR);
  assign m_tlast  = (state == ST_ERR) || (5'(ea) == acts_eff - 5'd1);
  assign m_tdata  = (state == ST_ERR) ? '0
                  : {7'b0, upd, best, logits[ea], ea};

endmodule

FILE: design/mp_checker.sv
`include "multiclass_perceptron_top_defines.svh"

module mp_checker
  import mp_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [M_DATA_W-1:0]   m_tdata,
  input logic                  m_tuser,
  input logic                  m_tlast
);

  `MP_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")
  `MP_ASSERT(a_one_side, !(s_tready && m_tvalid), "input taken while results pending")
  `MP_ASSERT(a_err_last, m_tvalid && m_tuser |-> m_tlast, "error result not marked last")
  `MP_ASSERT(a_err_zero, m_tvalid && m_tuser |-> m_tdata == '0, "error result carries data")
  `MP_ASSERT_ALWAYS(a_rst_clear, rst |=> !s_tready && !m_tvalid, "ready right after reset")

endmodule

bind multiclass_perceptron_top mp_checker u_mp_checker (.*);

FILE: verif/multiclass_perceptron_top_test.sv
module multiclass_perceptron_top_test;
  import mp_pkg::*;

  typedef struct packed {
    logic [CLS_W-1:0]   cls;
    logic [LOGIT_W-1:0] logit;
    logic [CLS_W-1:0]   best;
    logic               status;
    logic               upd;
    logic               last;
  } logit_result_t;

  localparam bit OP_PREDICT = 1'b0;
  localparam bit OP_TRAIN   = 1'b1;

  localparam int PAT_RANDOM = 0;
  localparam int PAT_MAX    = 1;
  localparam int PAT_MIN    = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [S_DATA_W-1:0]   s_tdata;
  logic                  s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [M_DATA_W-1:0]   m_tdata;
  logic                  m_tuser;
  logic                  m_tlast;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  multiclass_perceptron_top u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  logic signed [WEIGHT_W-1:0] weights [WDEPTH];
  logic signed [WEIGHT_W-1:0] biases [MAX_CLASSES];
  logic signed [FEAT_W-1:0]   features [MAX_FEATURES];
  int unsigned                loaded;
  logic [LEN_W-1:0]           vec_len;
  logic [ACT_W-1:0]           act_cnt;
  logic [STEP_W-1:0]          step;

  logit_result_t pending_logits [$];
  int            send_idle_pct;
  int            recv_idle_pct;
  bit            failed;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic int eff_len();
    if (vec_len == 0) return 1;
    if (vec_len > MAX_FEATURES) return MAX_FEATURES;
    return vec_len;
  endfunction

  function automatic int eff_actions();
    if (act_cnt == 0) return 1;
    if (act_cnt > MAX_CLASSES) return MAX_CLASSES;
    return act_cnt;
  endfunction

  function automatic logic signed [WEIGHT_W-1:0] sat32(longint v);
    if (v > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -64'sh8000_0000) return 32'sh8000_0000;
    return v[WEIGHT_W-1:0];
  endfunction

  function automatic void clear_model();
    foreach (weights[k]) weights[k] = '0;
    foreach (biases[k]) biases[k] = '0;
    loaded = 0;
  endfunction

  function automatic void classify(bit op, logic signed [FEAT_W-1:0] f, logic [3:0] tgt);
    int len;
    int acts;
    int best;
    longint acc;
    longint d;
    longint lg [MAX_CLASSES];
    bit upd;
    logit_result_t r;
    len = eff_len();
    acts = eff_actions();
    best = 0;
    upd = 0;
    if (loaded >= len) loaded = 0;
    features[loaded] = f;
    loaded++;
    if (loaded < len) return;
    loaded = 0;
    if (op && (tgt >= acts || step == 0)) begin
      r = '0;
      r.status = 1'b1;
      r.last = 1'b1;
      pending_logits.push_back(r);
      return;
    end
    for (int a = 0; a < acts; a++) begin
      acc = longint'(biases[a]) * 4096;
      for (int i = 0; i < len; i++)
        acc += longint'(features[i]) * longint'(weights[a*len + i]);
      lg[a] = acc >>> 12;
      if (a > 0 && lg[a] > lg[best]) best = a;
    end
    if (op && best != tgt) begin
      for (int i = 0; i < len; i++) begin
        d = (longint'(step) * longint'(features[i])) >>> 12;
        weights[tgt*len + i] = sat32(longint'(weights[tgt*len + i]) + d);
        weights[best*len + i] = sat32(longint'(weights[best*len + i]) - d);
      end
      biases[tgt] = sat32(longint'(biases[tgt]) + longint'(step));
      biases[best] = sat32(longint'(biases[best]) - longint'(step));
      upd = 1;
    end
    for (int a = 0; a < acts; a++) begin
      r.cls = CLS_W'(a);
      r.logit = lg[a][LOGIT_W-1:0];
      r.best = CLS_W'(best);
      r.status = 1'b0;
      r.upd = upd;
      r.last = (a + 1 == acts);
      pending_logits.push_back(r);
    end
  endfunction

  always @(negedge clk)
    m_tready <= ($urandom_range(99) >= recv_idle_pct);

  always @(posedge clk) begin
    logit_result_t got;
    logit_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.cls = m_tdata[3:0];
      got.logit = m_tdata[51:4];
      got.best = m_tdata[55:52];
      got.upd = m_tdata[56];
      got.status = m_tuser;
      got.last = m_tlast;
      if (pending_logits.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, got);
        failed = 1;
      end else begin
        want = pending_logits.pop_front();
        if (got !== want) begin
          $display("%0t: expected cls %0d logit %h best %0d st %b upd %b last %b",
                   $realtime, want.cls, want.logit, want.best, want.status, want.upd, want.last);
          $display("%0t: actual   cls %0d logit %h best %0d st %b upd %b last %b",
                   $realtime, got.cls, got.logit, got.best, got.status, got.upd, got.last);
          failed = 1;
        end
      end
    end
  end

  task automatic send_feature(bit op, logic signed [FEAT_W-1:0] f, logic [3:0] tgt);
    @(negedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {4'b0, tgt, f};
    s_tuser <= op;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    classify(op, f, tgt);
  endtask

  task automatic send_vector(bit op, logic [3:0] tgt, int pattern);
    int len;
    logic signed [FEAT_W-1:0] f;
    len = eff_len();
    for (int i = 0; i < len; i++) begin
      case (pattern)
        PAT_MAX: f = 16'sh7FFF;
        PAT_MIN: f = 16'sh8000;
        default: f = FEAT_W'($urandom);
      endcase
      send_feature(op, f, tgt);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_logits.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_VECTOR_LENGTH: begin
        vec_len = val[LEN_W-1:0];
        clear_model();
      end
      CFG_ACTION_COUNT: begin
        act_cnt = val[ACT_W-1:0];
        clear_model();
      end
      CFG_STEP_SIZE: step = val;
      default: ;
    endcase
  endtask

  task automatic test_reset_defaults();
    send_vector(OP_PREDICT, 4'd0, PAT_MAX);
    send_vector(OP_PREDICT, 4'd0, PAT_MIN);
    send_vector(OP_TRAIN, 4'd1, PAT_MAX);
    send_vector(OP_TRAIN, 4'd1, PAT_MIN);
    send_vector(OP_TRAIN, 4'd0, PAT_RANDOM);
    send_vector(OP_TRAIN, 4'd15, PAT_RANDOM);
    drain();
  endtask

  task automatic test_size_extremes();
    write_reg(CFG_VECTOR_LENGTH, 16'd0);
    write_reg(CFG_ACTION_COUNT, 16'd0);
    send_vector(OP_TRAIN, 4'd0, PAT_MAX);
    send_vector(OP_TRAIN, 4'd1, PAT_RANDOM);
    drain();
    write_reg(CFG_VECTOR_LENGTH, 16'hFFFF);
    write_reg(CFG_ACTION_COUNT, 16'hFFFF);
    write_reg(CFG_STEP_SIZE, 16'hFFFF);
    send_vector(OP_TRAIN, 4'd15, PAT_MAX);
    drain();
    write_reg(CFG_VECTOR_LENGTH, 16'd3);
    write_reg(CFG_ACTION_COUNT, 16'd16);
    send_vector(OP_TRAIN, 4'd7, PAT_MIN);
    send_vector(OP_PREDICT, 4'd0, PAT_RANDOM);
    drain();
    write_reg(CFG_STEP_SIZE, 16'd0);
    send_vector(OP_TRAIN, 4'd2, PAT_RANDOM);
    send_vector(OP_PREDICT, 4'd2, PAT_RANDOM);
    drain();
    write_reg(CFG_UNUSED_IDX, 16'h1234);
    send_vector(OP_PREDICT, 4'd0, PAT_RANDOM);
    drain();
  endtask

  task automatic test_random_training(int vectors);
    int acts;
    logic [3:0] tgt;
    write_reg(CFG_VECTOR_LENGTH, 16'($urandom_range(6, 1)));
    write_reg(CFG_ACTION_COUNT, 16'($urandom_range(16, 1)));
    write_reg(CFG_STEP_SIZE, ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom));
    acts = eff_actions();
    for (int v = 0; v < vectors; v++) begin
      tgt = ($urandom_range(9) == 0) ? 4'($urandom) : 4'($urandom_range(acts - 1));
      send_vector($urandom_range(3) != 0, tgt, ($urandom_range(9) == 0) ? PAT_MAX : PAT_RANDOM);
    end
    drain();
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    failed = 0;
    send_idle_pct = 33;
    recv_idle_pct = 84;
    vec_len = 1;
    act_cnt = 2;
    step = 4096;
    clear_model();
    foreach (features[k]) features[k] = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_defaults();
    test_size_extremes();
    test_random_training(6);
    send_idle_pct = 84;
    recv_idle_pct = 33;
    test_random_training(6);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_training(6);

    if (!failed) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
